@@ rtl/trie_insert_search_prefix_defines.svh @@
// ----------------------------------------------------------------------------
// Trie insert/search/prefix assertion macros
// Shared assertion forms for the checker of the trie block.
// ----------------------------------------------------------------------------
`ifndef TRIE_INSERT_SEARCH_PREFIX_DEFINES_SVH
`define TRIE_INSERT_SEARCH_PREFIX_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TISP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TISP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tisp_pkg.sv @@
// ----------------------------------------------------------------------------
// Trie package
// Types and constants shared by the trie controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tisp_pkg;

  localparam int NODE_COUNT_DEF    = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int MODE_W            = 2;
  localparam int LETTER_W          = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP,
    ST_MARK,
    ST_FIN
  } tisp_state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic step;
    logic finish;
  } tisp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last;
  } tisp_sts_t;

endpackage

`default_nettype wire

@@ rtl/tisp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Trie controller
// Sequences the clearing pass and the per-item lookup, step and result phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tisp_ctrl
  import tisp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire tisp_sts_t sts,
  output tisp_cmd_t      cmd
);

  tisp_state_t state_r;
  tisp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        state_nxt = sts.last ? ST_MARK : ST_IDLE;
      end
      ST_MARK: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    cmd     = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
      end
      ST_MARK: begin
        busy = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tisp_dp.sv @@
// ----------------------------------------------------------------------------
// Trie datapath
// Child-link and node-mark memories, the walk registers and the result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tisp_dp
  import tisp_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tisp_cmd_t           cmd,
  output tisp_sts_t                sts,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [LETTER_W-1:0] in_letter,
  input  wire logic                in_has_letter,
  input  wire logic                in_last,
  output logic                     out_valid,
  output logic                     out_found,
  output logic                     out_pool_full
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int SLOTS  = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W = $clog2(SLOTS);

  logic [NODE_W-1:0] child_mem [SLOTS];
  logic              end_mem   [NODE_COUNT];
  logic              hc_mem    [NODE_COUNT];

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              ok_r, ok_nxt;
  logic              has_r, has_nxt;
  logic              last_r, last_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [NODE_W-1:0] walk_r, walk_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic              broken_r, broken_nxt;
  logic              ovf_r, ovf_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_full_r, out_full_nxt;

  logic [NODE_W-1:0] child_rd_r;
  logic              end_rd_r;
  logic              hc_rd_r;

  logic              letter_ok;
  logic [SLOT_W-1:0] slot_calc;

  logic              cw_en;
  logic [SLOT_W-1:0] cw_addr;
  logic [NODE_W-1:0] cw_data;
  logic              ew_en;
  logic [NODE_W-1:0] ew_addr;
  logic              ew_data;
  logic              hw_en;
  logic [NODE_W-1:0] hw_addr;
  logic              hw_data;

  always_comb begin
    letter_ok = (32'(in_letter) < ALPHABET_SIZE);
    slot_calc = '0;
    if (in_has_letter && letter_ok) begin
      slot_calc = SLOT_W'(32'(walk_r) * 32'(ALPHABET_SIZE) + 32'(in_letter));
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      child_mem[cw_addr] <= cw_data;
    end
    child_rd_r <= child_mem[slot_calc];
  end

  always_ff @(posedge clk) begin
    if (ew_en) begin
      end_mem[ew_addr] <= ew_data;
    end
    end_rd_r <= end_mem[walk_r];
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      hc_mem[hw_addr] <= hw_data;
    end
    hc_rd_r <= hc_mem[walk_r];
  end

  always_comb begin
    mode_nxt      = mode_r;
    ok_nxt        = ok_r;
    has_nxt       = has_r;
    last_nxt      = last_r;
    slot_nxt      = slot_r;
    walk_nxt      = walk_r;
    free_nxt      = free_r;
    broken_nxt    = broken_r;
    ovf_nxt       = ovf_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    cw_en         = 1'b0;
    cw_addr       = slot_r;
    cw_data       = free_r[NODE_W-1:0];
    ew_en         = 1'b0;
    ew_addr       = walk_r;
    ew_data       = 1'b1;
    hw_en         = 1'b0;
    hw_addr       = walk_r;
    hw_data       = 1'b1;

    if (cmd.clear) begin
      cw_en   = 1'b1;
      cw_addr = clr_r;
      cw_data = '0;
      if (32'(clr_r) < NODE_COUNT) begin
        ew_en   = 1'b1;
        ew_addr = clr_r[NODE_W-1:0];
        ew_data = 1'b0;
        hw_en   = 1'b1;
        hw_addr = clr_r[NODE_W-1:0];
        hw_data = 1'b0;
      end
      clr_nxt = clr_r + 1'b1;
    end

    if (cmd.capture) begin
      mode_nxt = in_mode;
      ok_nxt   = letter_ok;
      has_nxt  = in_has_letter;
      last_nxt = in_last;
      slot_nxt = slot_calc;
    end

    if (cmd.step && has_r && !broken_r) begin
      if (!ok_r) begin
        broken_nxt = 1'b1;
      end else if (child_rd_r != '0) begin
        walk_nxt = child_rd_r;
      end else if (mode_r != MODE_INSERT) begin
        broken_nxt = 1'b1;
      end else if (free_r == CNT_W'(NODE_COUNT)) begin
        ovf_nxt    = 1'b1;
        broken_nxt = 1'b1;
      end else begin
        cw_en    = 1'b1;
        hw_en    = 1'b1;
        walk_nxt = free_r[NODE_W-1:0];
        free_nxt = free_r + 1'b1;
      end
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_full_nxt  = 1'b0;
      case (mode_r)
        MODE_INSERT: begin
          out_full_nxt  = ovf_r;
          out_found_nxt = !ovf_r && !broken_r;
          ew_en         = !ovf_r && !broken_r;
        end
        MODE_PREFIX: begin
          out_found_nxt = !broken_r && (end_rd_r || hc_rd_r);
        end
        MODE_SEARCH: begin
          out_found_nxt = !broken_r && end_rd_r;
        end
        default: begin
          out_found_nxt = !broken_r && end_rd_r;
        end
      endcase
      walk_nxt   = '0;
      broken_nxt = 1'b0;
      ovf_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r      <= '0;
      free_r      <= CNT_W'(1);
      broken_r    <= 1'b0;
      ovf_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      walk_r      <= walk_nxt;
      free_r      <= free_nxt;
      broken_r    <= broken_nxt;
      ovf_r       <= ovf_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    ok_r        <= ok_nxt;
    has_r       <= has_nxt;
    last_r      <= last_nxt;
    slot_r      <= slot_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign sts.clear_done = (clr_r == SLOT_W'(SLOTS - 1));
  assign sts.last       = last_r;
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_pool_full  = out_full_r;

endmodule

`default_nettype wire

@@ rtl/trie_insert_search_prefix.sv @@
// ----------------------------------------------------------------------------
// Trie insert, search and prefix query
// Letter-at-a-time trie over a node table with a free-node allocator.
// ----------------------------------------------------------------------------
// An item is one letter of a word and is taken on a rising edge with start
// high and busy low. Each item carries its mode (insert, search, prefix), the
// letter, a letter-present flag and a last flag that closes the word.
// For a letter item the child link is read from the link memory in the
// accept cycle, and the walk moves or allocates in the next one.
// The last item of a word goes on through a read of the marks of the node
// reached from the mark memories before the answer is formed.
// The result is shown for one cycle on out_found and out_pool_full with
// out_valid high, in the cycle after the word finishes; the block is idle
// again in that same cycle. The receiver cannot hold a result off.
// After reset the block clears its link memory, one entry per cycle, all
// NODE_COUNT * ALPHABET_SIZE entries (26624 by default); busy stays high
// until the pass is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trie_insert_search_prefix
  import tisp_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [LETTER_W-1:0] in_letter,
  input  wire logic                in_has_letter,
  input  wire logic                in_last,
  output logic                     out_valid,
  output logic                     out_found,
  output logic                     out_pool_full
);

  tisp_cmd_t cmd;
  tisp_sts_t sts;

  tisp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tisp_dp #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_mode),
    .in_letter     (in_letter),
    .in_has_letter (in_has_letter),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_pool_full (out_pool_full)
  );

endmodule

`default_nettype wire

@@ rtl/tisp_checker.sv @@
// ----------------------------------------------------------------------------
// Trie port checker
// Timing and result checks on the ports of the trie block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "trie_insert_search_prefix_defines.svh"

module tisp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_found,
  input wire logic out_pool_full
);

  `TISP_ASSERT_NEXT(a_no_result_after_accept, start && !busy, !out_valid, "result right after an accepted item")
  `TISP_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `TISP_ASSERT_NOW(a_result_when_idle, out_valid, !busy, "result shown while busy")
  `TISP_ASSERT_NOW(a_full_not_found, out_valid && out_pool_full, !out_found, "word reported stored on pool overflow")

endmodule

bind trie_insert_search_prefix tisp_checker u_tisp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_found     (out_found),
  .out_pool_full (out_pool_full)
);

`default_nettype wire
